// ===== rtl/wws_pkg.sv =====
// shared types, codes and fixed-point constants of the windowed waveform shaper
`timescale 1ns / 1ps
package wws_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int SHAPE_W = 3;
  localparam int DECAY_W = 16;
  localparam int CURVE_STAGES = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SHAPE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WSTART = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEND   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 2'd3;

  localparam logic [SHAPE_W-1:0] SHP_GATE = 3'd0;
  localparam logic [SHAPE_W-1:0] SHP_RAMP = 3'd1;
  localparam logic [SHAPE_W-1:0] SHP_TRI  = 3'd2;
  localparam logic [SHAPE_W-1:0] SHP_COS  = 3'd3;
  localparam logic [SHAPE_W-1:0] SHP_EXP  = 3'd4;

  localparam logic [DECAY_W-1:0] DECAY_RST = 16'd256;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [29:0] Q29 = 30'h2000_0000;
  localparam logic [29:0] Q28 = 30'h1000_0000;

  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [22:0] LOG2E_Q22 = 23'd6051102;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // reciprocal multipliers, exact floor for 30-bit operands
  localparam int unsigned K6 = 33;
  localparam int unsigned K24 = 35;
  localparam int unsigned K120 = 37;
  localparam int unsigned K720 = 40;
  localparam int unsigned K5040 = 43;
  localparam int unsigned K40320 = 46;
  localparam logic [31:0] M6 = 32'(((64'd1 << K6) + 64'd5) / 64'd6);
  localparam logic [31:0] M24 = 32'(((64'd1 << K24) + 64'd23) / 64'd24);
  localparam logic [31:0] M120 = 32'(((64'd1 << K120) + 64'd119) / 64'd120);
  localparam logic [31:0] M720 = 32'(((64'd1 << K720) + 64'd719) / 64'd720);
  localparam logic [31:0] M5040 = 32'(((64'd1 << K5040) + 64'd5039) / 64'd5040);
  localparam logic [31:0] M40320 = 32'(((64'd1 << K40320) + 64'd40319) / 64'd40320);

  typedef struct packed {
    logic [SHAPE_W-1:0] shape;
    logic [DECAY_W-1:0] decay_rate;
  } wws_ccfg_t;

  function automatic logic [29:0] mul30(input logic [29:0] a, input logic [29:0] b);
    logic [59:0] p;
    p = 60'(a) * 60'(b);
    return 30'(p >> 30);
  endfunction

  function automatic logic [29:0] cdiv(input logic [29:0] n, input logic [31:0] m,
                                       input int unsigned k);
    logic [61:0] p;
    p = 62'(n) * 62'(m);
    return 30'(p >> k);
  endfunction

endpackage

// ===== rtl/wws_if.sv =====
// valid/ready channel interfaces for phase samples and levels
`timescale 1ns / 1ps
interface wws_in_if #(parameter int PHASE_BITS = 16) ();
  logic                  valid;
  logic                  ready;
  logic [PHASE_BITS-1:0] phase;
  modport source (output valid, output phase, input ready);
  modport sink (input valid, input phase, output ready);
endinterface

interface wws_out_if #(parameter int LEVEL_FRAC_BITS = 16) ();
  logic                     valid;
  logic                     ready;
  logic [LEVEL_FRAC_BITS:0] level;
  logic                     in_window;
  modport source (output valid, output level, output in_window, input ready);
  modport sink (input valid, input level, input in_window, output ready);
endinterface

// ===== rtl/wws_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module wws_div #(
  parameter int PW = 16,
  parameter int LFB = 16
) (
  input  logic           clk,
  input  logic [LFB-1:0] adv,
  input  logic [PW:0]    rem_i,
  input  logic [PW:0]    len_i,
  input  logic           win_i,
  output logic [LFB-1:0] quo_o,
  output logic           win_o
);

  logic [PW:0]    rem_r [LFB];
  logic [PW:0]    len_r [LFB];
  logic [LFB-1:0] quo_r [LFB];
  logic           win_r [LFB];

  for (genvar i = 0; i < LFB; i++) begin : g_stg
    logic [PW:0]    rem_s;
    logic [PW:0]    len_s;
    logic [LFB-1:0] quo_s;
    logic           win_s;
    logic [PW+1:0]  dbl;
    logic           ge;
    logic [PW:0]    rem_nxt;
    logic [LFB-1:0] quo_nxt;

    if (i == 0) begin : g_first
      assign rem_s = rem_i;
      assign len_s = len_i;
      assign quo_s = '0;
      assign win_s = win_i;
    end else begin : g_next
      assign rem_s = rem_r[i-1];
      assign len_s = len_r[i-1];
      assign quo_s = quo_r[i-1];
      assign win_s = win_r[i-1];
    end

    always_comb begin
      dbl = {rem_s, 1'b0};
      ge = dbl >= {1'b0, len_s};
      rem_nxt = ge ? (PW+1)'(dbl - {1'b0, len_s}) : (PW+1)'(dbl);
      quo_nxt = {quo_s[LFB-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (adv[i]) begin
        rem_r[i] <= rem_nxt;
        len_r[i] <= len_s;
        quo_r[i] <= quo_nxt;
        win_r[i] <= win_s;
      end
    end
  end

  assign quo_o = quo_r[LFB-1];
  assign win_o = win_r[LFB-1];

endmodule

// ===== rtl/wws_curve.sv =====
// shape evaluation pipeline: gate, ramp, triangle, raised cosine, exponential decay
`timescale 1ns / 1ps
module wws_curve import wws_pkg::*; #(
  parameter int LFB = 16
) (
  input  logic                    clk,
  input  logic [CURVE_STAGES-1:0] adv,
  input  wws_ccfg_t               cfg,
  input  logic [LFB-1:0]          u_i,
  input  logic                    win_i,
  output logic [LFB:0]            level_o,
  output logic                    win_o
);

  localparam logic [LFB:0] ONE = {1'b1, {LFB{1'b0}}};
  localparam int RSH = 30 - LFB;

  logic [LFB:0]  um;
  logic [LFB-1:0] v;
  logic [29:0]   w;
  logic          fold;
  logic [29:0]   wf;
  logic [60:0]   xp;
  logic [29:0]   x1;
  logic [LFB:0]  lvs;
  logic [15:0]   k;
  logic [23:0]   u24;
  logic [39:0]   y;
  logic [40:0]   z;
  logic [29:0]   g;
  logic [30:0]   sqc;
  logic [30:0]   sqf;
  logic [LFB:0]  lcos;
  logic [31:0]   ev;
  logic [31:0]   od;
  logic [5:0]    sh;
  logic [32:0]   rnd;
  logic [32:0]   lsel;
  logic [LFB:0]  lclamp;

  logic          win_p [1:13];
  logic [LFB:0]  lvl_p [1:12];
  logic          fold_p [1:8];
  logic [29:0]   x_p [1:6];
  logic [29:0]   x2_p [2:4];
  logic [29:0]   x3_p [3:5];
  logic [29:0]   x5_p [4:5];
  logic [29:0]   x7_r;
  logic [29:0]   q3_r;
  logic [29:0]   q5_r;
  logic [29:0]   q7_r;
  logic [29:0]   s_r;
  logic [29:0]   sq_r;
  logic [39:0]   y_r;
  logic [8:0]    n_r;
  logic [31:0]   f_r;
  logic [29:0]   gp_r [3:10][1:8];
  logic          big_p [3:12];
  logic [4:0]    ns_p [3:12];
  logic [29:0]   h2_r, h4_r, h6_r, h8_r;
  logic [29:0]   o1_r, o3_r, o5_r, o7_r;
  logic [31:0]   e_r;
  logic [LFB:0]  level_r;

  always_comb begin
    um = ONE - {1'b0, u_i};
    v = ({1'b0, u_i} < um) ? u_i : um[LFB-1:0];
    w = 30'(v) << RSH;
    fold = w > Q28;
    wf = fold ? (Q29 - w) : w;
    xp = 61'(wf) * 61'(PI_Q30);
    x1 = 30'(xp >> 30);
    case (cfg.shape)
      SHP_GATE: lvs = ONE;
      SHP_RAMP: lvs = {1'b0, u_i};
      SHP_TRI:  lvs = u_i[LFB-1] ? {um[LFB-1:0], 1'b0} : {u_i, 1'b0};
      default:  lvs = '0;
    endcase
    k = (cfg.decay_rate == '0) ? DECAY_RST : cfg.decay_rate;
    u24 = 24'(u_i) << (24 - LFB);
    y = 40'(k) * 40'(u24);
  end

  always_comb begin
    z = 41'((63'(y_r) * 63'(LOG2E_Q22)) >> 22);
    g = 30'((62'(f_r) * 62'(LN2_Q30)) >> 32);
  end

  always_comb begin
    sqc = (31'(sq_r) > Q30_ONE) ? Q30_ONE : 31'(sq_r);
    sqf = fold_p[8] ? (Q30_ONE - sqc) : sqc;
    lcos = (LFB+1)'((32'(sqf) + (32'd1 << (RSH - 1))) >> RSH);
  end

  always_comb begin
    ev = 32'(Q30_ONE) + 32'(h2_r) + 32'(h4_r) + 32'(h6_r) + 32'(h8_r);
    od = 32'(o1_r) + 32'(o3_r) + 32'(o5_r) + 32'(o7_r);
  end

  always_comb begin
    sh = 6'(RSH) + 6'(ns_p[12]);
    rnd = (33'(e_r) + (33'd1 << (sh - 6'd1))) >> sh;
    if (cfg.shape == SHP_EXP) begin
      lsel = big_p[12] ? '0 : rnd;
    end else begin
      lsel = 33'(lvl_p[12]);
    end
    lclamp = (lsel > 33'(ONE)) ? ONE : lsel[LFB:0];
  end

  always_ff @(posedge clk) begin
    for (int t = 2; t <= 13; t++) begin
      if (adv[t-1]) begin
        win_p[t] <= win_p[t-1];
      end
    end
    for (int t = 2; t <= 12; t++) begin
      if (adv[t-1] && t != 9) begin
        lvl_p[t] <= lvl_p[t-1];
      end
    end
    for (int t = 2; t <= 8; t++) begin
      if (adv[t-1]) begin
        fold_p[t] <= fold_p[t-1];
      end
    end
    for (int t = 4; t <= 12; t++) begin
      if (adv[t-1]) begin
        big_p[t] <= big_p[t-1];
        ns_p[t] <= ns_p[t-1];
      end
    end
    for (int t = 4; t <= 10; t++) begin
      if (adv[t-1]) begin
        for (int j = 1; j <= t - 3; j++) begin
          gp_r[t][j] <= gp_r[t-1][j];
        end
        gp_r[t][t-2] <= mul30(gp_r[t-1][t-3], gp_r[t-1][1]);
      end
    end
    for (int t = 2; t <= 6; t++) begin
      if (adv[t-1]) begin
        x_p[t] <= x_p[t-1];
      end
    end

    if (adv[0]) begin
      win_p[1] <= win_i;
      lvl_p[1] <= lvs;
      fold_p[1] <= fold;
      x_p[1] <= x1;
      y_r <= y;
    end
    if (adv[1]) begin
      x2_p[2] <= mul30(x_p[1], x_p[1]);
      n_r <= z[40:32];
      f_r <= z[31:0];
    end
    if (adv[2]) begin
      x2_p[3] <= x2_p[2];
      x3_p[3] <= mul30(x2_p[2], x_p[2]);
      gp_r[3][1] <= g;
      big_p[3] <= n_r >= 9'(LFB + 2);
      ns_p[3] <= n_r[4:0];
    end
    if (adv[3]) begin
      x2_p[4] <= x2_p[3];
      x3_p[4] <= x3_p[3];
      x5_p[4] <= mul30(x3_p[3], x2_p[3]);
    end
    if (adv[4]) begin
      x3_p[5] <= x3_p[4];
      x5_p[5] <= x5_p[4];
      x7_r <= mul30(x5_p[4], x2_p[4]);
    end
    if (adv[5]) begin
      q3_r <= cdiv(x3_p[5], M6, K6);
      q5_r <= cdiv(x5_p[5], M120, K120);
      q7_r <= cdiv(x7_r, M5040, K5040);
    end
    if (adv[6]) begin
      s_r <= (x_p[6] - q3_r) + (q5_r - q7_r);
    end
    if (adv[7]) begin
      sq_r <= mul30(s_r, s_r);
    end
    if (adv[8]) begin
      lvl_p[9] <= (cfg.shape == SHP_COS) ? lcos : lvl_p[8];
    end
    if (adv[10]) begin
      h2_r <= gp_r[10][2] >> 1;
      h4_r <= cdiv(gp_r[10][4], M24, K24);
      h6_r <= cdiv(gp_r[10][6], M720, K720);
      h8_r <= cdiv(gp_r[10][8], M40320, K40320);
      o1_r <= gp_r[10][1];
      o3_r <= cdiv(gp_r[10][3], M6, K6);
      o5_r <= cdiv(gp_r[10][5], M120, K120);
      o7_r <= cdiv(gp_r[10][7], M5040, K5040);
    end
    if (adv[11]) begin
      e_r <= (ev > od) ? (ev - od) : '0;
    end
    if (adv[12]) begin
      level_r <= win_p[12] ? lclamp : '0;
    end
  end

  assign level_o = level_r;
  assign win_o = win_p[13];

endmodule

// ===== rtl/windowed_waveform_shaper.sv =====
// top level of the windowed waveform shaper
`timescale 1ns / 1ps
// channels: in_ch carries one phase sample per transaction, out_ch one level
//   and an in_window flag per transaction, in the same order
// cfg_*: register writes (shape, window start, window end, decay rate),
//   always ready and applied at once, so issue them only while the block is idle
// path: an accepted phase reaches its level through one input stage, one
//   divider stage per quotient bit of the window position and 13 stages of
//   shape arithmetic
// throughput: one transaction per cycle in each direction while out_ch.ready is high or the pipeline has a gap
// stalls: valid bits travel with the data and any empty stage closes up, so
//   input is taken while a result waits as long as the pipeline has a gap;
//   with every stage full and out_ch.ready low, in_ch.ready drops
// reset: all stages empty, shape gate, window the full period, decay 1.0
module windowed_waveform_shaper import wws_pkg::*; #(
  parameter int PHASE_BITS = 16,
  parameter int LEVEL_FRAC_BITS = 16,
  localparam int CFG_DW = (PHASE_BITS + 1 > DECAY_W) ? PHASE_BITS + 1 : DECAY_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  wws_in_if.sink               in_ch,
  wws_out_if.source            out_ch,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data
);

  localparam int NS = LEVEL_FRAC_BITS + 1 + CURVE_STAGES;

  logic [SHAPE_W-1:0]     shape_r;
  logic [PHASE_BITS-1:0]  wstart_r;
  logic [PHASE_BITS:0]    wend_r;
  logic [DECAY_W-1:0]     decay_r;

  logic [NS-1:0]          vld_r;
  logic [NS-1:0]          vld_nxt;
  logic [NS-1:0]          adv;
  logic [NS-1:0]          bub;

  logic [PHASE_BITS-1:0]  ph;
  logic                   win_nxt;
  logic [PHASE_BITS:0]    dd_nxt;
  logic [PHASE_BITS:0]    len_nxt;
  logic                   win_r;
  logic [PHASE_BITS:0]    dd_r;
  logic [PHASE_BITS:0]    len_r;

  logic [LEVEL_FRAC_BITS-1:0] u;
  logic                       win_d;
  logic [LEVEL_FRAC_BITS:0]   level;
  logic                       win_c;
  wws_ccfg_t                  ccfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r <= SHP_GATE;
      wstart_r <= '0;
      wend_r <= (PHASE_BITS+1)'(1) << PHASE_BITS;
      decay_r <= DECAY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SHAPE:  shape_r <= cfg_data[SHAPE_W-1:0];
        REG_WSTART: wstart_r <= cfg_data[PHASE_BITS-1:0];
        REG_WEND:   wend_r <= cfg_data[PHASE_BITS:0];
        REG_DECAY:  decay_r <= cfg_data[DECAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    bub = ~vld_r;
    for (int i = 0; i < NS; i++) begin
      adv[i] = out_ch.ready || (|(bub >> i));
    end
    vld_nxt[0] = adv[0] ? in_ch.valid : vld_r[0];
    for (int i = 1; i < NS; i++) begin
      vld_nxt[i] = adv[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready = adv[0];

  always_comb begin
    ph = in_ch.phase;
    win_nxt = ({1'b0, wstart_r} < wend_r) && (ph >= wstart_r) && ({1'b0, ph} < wend_r);
    dd_nxt = {1'b0, ph} - {1'b0, wstart_r};
    len_nxt = wend_r - {1'b0, wstart_r};
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      win_r <= win_nxt;
      dd_r <= dd_nxt;
      len_r <= len_nxt;
    end
  end

  wws_div #(
    .PW (PHASE_BITS),
    .LFB(LEVEL_FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .adv  (adv[LEVEL_FRAC_BITS:1]),
    .rem_i(dd_r),
    .len_i(len_r),
    .win_i(win_r),
    .quo_o(u),
    .win_o(win_d)
  );

  assign ccfg.shape = shape_r;
  assign ccfg.decay_rate = decay_r;

  wws_curve #(
    .LFB(LEVEL_FRAC_BITS)
  ) u_curve (
    .clk    (clk),
    .adv    (adv[NS-1:LEVEL_FRAC_BITS+1]),
    .cfg    (ccfg),
    .u_i    (u),
    .win_i  (win_d),
    .level_o(level),
    .win_o  (win_c)
  );

  assign out_ch.valid = vld_r[NS-1];
  assign out_ch.level = level;
  assign out_ch.in_window = win_c;

endmodule

// ===== rtl/wws_chk.sv =====
// port-level assertions for the windowed waveform shaper, bound to the top level
`timescale 1ns / 1ps
module wws_chk #(
  parameter int LEVEL_FRAC_BITS = 16
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [LEVEL_FRAC_BITS:0] out_level,
  input logic                     out_in_window
);

  localparam logic [LEVEL_FRAC_BITS:0] ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_in_window))
    else $error("stalled result changed");

  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level <= ONE)
    else $error("level above one");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_window |-> out_level == '0)
    else $error("nonzero level outside window");

  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output stage");

endmodule

bind windowed_waveform_shaper wws_chk #(
  .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
) u_wws_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_level    (out_ch.level),
  .out_in_window(out_ch.in_window)
);

// ===== tb/tb_top.sv =====
// testbench for the windowed waveform shaper: directed and random phases vs a level predictor
`timescale 1ns / 1ps
module tb_top;
  import wws_pkg::*;

  localparam int PB = 16;
  localparam int LB = 16;
  localparam int CDW = 17;
  localparam int DRAIN = 80;

  typedef struct {
    logic [LB:0] level;
    logic        in_window;
  } level_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CDW-1:0] cfg_data = '0;
  logic cfg_ready;

  wws_in_if #(.PHASE_BITS(PB)) in_ch ();
  wws_out_if #(.LEVEL_FRAC_BITS(LB)) out_ch ();

  windowed_waveform_shaper #(.PHASE_BITS(PB), .LEVEL_FRAC_BITS(LB)) u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  logic [2:0] cur_shape = SHP_GATE;
  logic [15:0] cur_wstart = 16'd0;
  logic [16:0] cur_wend = 17'd65536;
  logic [15:0] cur_decay = DECAY_RST;
  level_t pending_levels[$];
  int errors = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.phase = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [63:0] m30(logic [63:0] a, logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  function automatic logic [63:0] cos_level(logic [63:0] u);
    logic [63:0] v, w, x, x2, x3, x5, x7, s, sq;
    bit fold;
    v = (u < 65536 - u) ? u : 65536 - u;
    w = v << 14;
    fold = 0;
    if (w > (64'd1 << 28)) begin
      w = (64'd1 << 29) - w;
      fold = 1;
    end
    x = (w * 64'd3373259426) >> 30;
    x2 = m30(x, x);
    x3 = m30(x2, x);
    x5 = m30(x3, x2);
    x7 = m30(x5, x2);
    s = (x - x3 / 6) + (x5 / 120 - x7 / 5040);
    sq = m30(s, s);
    if (sq > (64'd1 << 30)) sq = 64'd1 << 30;
    if (fold) sq = (64'd1 << 30) - sq;
    return (sq + (64'd1 << 13)) >> 14;
  endfunction

  function automatic logic [63:0] decay_level(logic [63:0] u);
    logic [63:0] k, y, z, n, f, g, g2, g3, g4, g5, g6, g7, g8, ev, od, e;
    k = (cur_decay != 0) ? cur_decay : 64'd256;
    y = k * (u << 8);
    z = (y * 64'd6051102) >> 22;
    n = z >> 32;
    f = z & 64'hFFFF_FFFF;
    if (n >= 18) return 0;
    g = (f * 64'd744261118) >> 32;
    g2 = m30(g, g); g3 = m30(g2, g); g4 = m30(g3, g); g5 = m30(g4, g);
    g6 = m30(g5, g); g7 = m30(g6, g); g8 = m30(g7, g);
    ev = (64'd1 << 30) + g2 / 2 + g4 / 24 + g6 / 720 + g8 / 40320;
    od = g + g3 / 6 + g5 / 120 + g7 / 5040;
    e = (ev > od) ? ev - od : 0;
    return (e + (64'd1 << (13 + n))) >> (14 + n);
  endfunction

  function automatic level_t shape_level(logic [15:0] phase);
    level_t r;
    logic [63:0] u, lv;
    r.in_window = (cur_wstart < cur_wend) && (phase >= cur_wstart) && (phase < cur_wend);
    lv = 0;
    if (r.in_window) begin
      u = ((64'(phase) - cur_wstart) << 16) / (64'(cur_wend) - cur_wstart);
      if (u > 65536) u = 65536;
      case (cur_shape)
        SHP_GATE: lv = 65536;
        SHP_RAMP: lv = u;
        SHP_TRI: lv = (u < 32768) ? 2 * u : 2 * (65536 - u);
        SHP_COS: lv = cos_level(u);
        SHP_EXP: lv = decay_level(u);
        default: lv = 0;
      endcase
      if (lv > 65536) lv = 65536;
    end
    r.level = lv[16:0];
    return r;
  endfunction

  task automatic gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_phase(logic [15:0] phase);
    gap();
    in_ch.valid <= 1'b1;
    in_ch.phase <= phase;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_levels.push_back(shape_level(phase));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CDW-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SHAPE: cur_shape = data[2:0];
      REG_WSTART: cur_wstart = data[15:0];
      REG_WEND: cur_wend = data[16:0];
      REG_DECAY: cur_decay = data[15:0];
      default: ;
    endcase
  endtask

  // result checker; also drives out_ch.ready with random stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_levels.size() == 0) begin
          $error("unexpected transaction level=%0d", out_ch.level);
          errors++;
        end else begin
          level_t e;
          e = pending_levels.pop_front();
          if (out_ch.level !== e.level) begin
            $error("level expected %0d actual %0d", e.level, out_ch.level);
            errors++;
          end
          if (out_ch.in_window !== e.in_window) begin
            $error("in_window expected %0d actual %0d", e.in_window, out_ch.in_window);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic test_edges();
    logic [15:0] pts[6] = '{16'd0, 16'd1, 16'd32767, 16'd32768, 16'd65534, 16'd65535};
    foreach (pts[i]) send_phase(pts[i]);
    for (int s = 0; s < 8; s++) begin
      write_reg(REG_SHAPE, 17'(s));
      send_phase(16'd0);
      send_phase(16'hAAAA);
      send_phase(16'h5555);
    end
  endtask

  task automatic test_windows();
    write_reg(REG_SHAPE, 17'(SHP_RAMP));
    write_reg(REG_WSTART, 17'd1000);
    write_reg(REG_WEND, 17'd1000);
    send_phase(16'd1000);
    write_reg(REG_WEND, 17'd500);
    send_phase(16'd700);
    write_reg(REG_WEND, 17'd1001);
    send_phase(16'd999);
    send_phase(16'd1000);
    send_phase(16'd1001);
    write_reg(REG_WSTART, 17'd65535);
    write_reg(REG_WEND, 17'd65536);
    send_phase(16'd65535);
    write_reg(REG_SHAPE, 17'(SHP_EXP));
    write_reg(REG_WSTART, 17'd0);
    write_reg(REG_DECAY, 17'd0);
    send_phase(16'd40000);
    write_reg(REG_DECAY, 17'd65535);
    send_phase(16'd1);
    send_phase(16'd65535);
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 10; ph++) begin
      logic [16:0] a, b;
      a = $urandom_range(0, 65535);
      b = $urandom_range(0, 65536);
      if ($urandom_range(0, 5) != 0 && a > b) begin
        a = b[15:0] == 0 ? 17'd0 : 17'(b[15:0]);
        b = 17'($urandom_range(a, 65536));
      end
      if (ph == 9) idle_on = 1'b0;
      write_reg(REG_SHAPE, 17'($urandom_range(0, 7)));
      write_reg(REG_WSTART, a);
      write_reg(REG_WEND, b);
      write_reg(REG_DECAY, ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 65535))
                                                      : 17'($urandom_range(0, 2048)));
      for (int i = 0; i < 120; i++) begin
        if ($urandom_range(0, 1)) send_phase(16'($urandom_range(0, 65535)));
        else send_phase(16'($urandom_range(a[15:0], (b > 0) ? b - 1 : 0)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edges();
    test_windows();
    test_random();
    drain();
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/wws_pkg.sv
rtl/wws_if.sv
rtl/wws_div.sv
rtl/wws_curve.sv
rtl/windowed_waveform_shaper.sv
rtl/wws_chk.sv
tb/tb_top.sv
